// ===== src/efg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package efg_pkg;

  localparam int WAITERS_DEF = 8;
  localparam int MASK_W = 32;
  localparam int ID_W = 8;

  localparam logic OP_SEND = 1'b0;
  localparam logic OP_RECV = 1'b1;

  typedef enum logic [1:0] {
    KIND_RECV = 2'd0,
    KIND_WAKE = 2'd1,
    KIND_DONE = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_UNMET  = 3'd2,
    ST_QUEUED = 3'd3,
    ST_FULL   = 3'd4
  } status_t;

  typedef struct packed {
    logic              operation;
    logic [MASK_W-1:0] bits;
    logic [ID_W-1:0]   waiter_id;
    logic              match_all;
    logic              clear_on_take;
    logic              may_wait;
  } req_t;

  typedef struct packed {
    kind_t             kind;
    status_t           status;
    logic [ID_W-1:0]   woken_id;
    logic [MASK_W-1:0] taken_bits;
    logic              last;
  } rsp_t;

  typedef struct packed {
    logic [MASK_W-1:0] mask;
    logic [ID_W-1:0]   id;
    logic              all;
    logic              clr;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_WALK = 2'd1,
    S_DONE = 2'd2
  } state_t;

  typedef struct packed {
    logic take_in;
    logic step;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic is_send;
    logic empty;
    logic count_zero;
    logic slot_hit;
    logic slot_last;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/event_flag_group_waiters_top.sv =====
// Event flag group: a 32-bit flag word and a FIFO of up to WAITERS waiters.
// Request channel (req_valid / req_stall / req): operation 0 sends bits into
// the flags, operation 1 receives, either at once, failing, or by queueing.
// Response channel (rsp_valid / rsp_stall / rsp): a receive returns one
// transaction; a send returns one wake transaction per woken waiter in queue
// order, then a done transaction with last set.
// A receive result is registered and valid the cycle after the request is taken.
// A send first merges its bits into the flags, then walks the queued waiters,
// reading one slot per cycle from the slot RAM while no stalled response holds
// back a woken waiter, and then emits done. One request is in work at a
// time; a new request is taken only once the previous one has finished and
// the response register is free or being drained.
// Reset clears the flags, the queue count and the response valid flag; the
// slot RAM needs no clearing since only queued slots are ever read.
// A stalled response holds its payload and pauses a send walk at the next
// woken waiter; req_stall stays high until the response register frees up and no send is in work.
`timescale 1ns / 1ps
`default_nettype none

module event_flag_group_waiters_top #(
  parameter int WAITERS = efg_pkg::WAITERS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire efg_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output efg_pkg::rsp_t      rsp
);

  efg_pkg::cmd_t  cmd;
  efg_pkg::stat_t stat;

  efg_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  efg_dp #(
    .WAITERS (WAITERS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

// ===== src/efg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module efg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/efg_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module efg_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire efg_pkg::stat_t stat,
  output efg_pkg::cmd_t      cmd
);

  efg_pkg::state_t state;
  efg_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= efg_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    req_stall = 1'b1;
    case (state)
      efg_pkg::S_IDLE: begin
        req_stall = !stat.out_free;
        if (req_valid && stat.out_free) begin
          cmd.take_in = 1'b1;
          if (stat.is_send && !stat.empty) begin
            state_next = stat.count_zero ? efg_pkg::S_DONE : efg_pkg::S_WALK;
          end
        end
      end
      efg_pkg::S_WALK: begin
        if (!stat.slot_hit || stat.out_free) begin
          cmd.step = 1'b1;
          if (stat.slot_last) begin
            state_next = efg_pkg::S_DONE;
          end
        end
      end
      efg_pkg::S_DONE: begin
        if (stat.out_free) begin
          cmd.emit_done = 1'b1;
          state_next = efg_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = efg_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/efg_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module efg_dp #(
  parameter int WAITERS = efg_pkg::WAITERS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire efg_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output efg_pkg::rsp_t       rsp,
  input  wire efg_pkg::cmd_t  cmd,
  output efg_pkg::stat_t      stat
);

  localparam int CW = $clog2(WAITERS + 1);
  localparam int IW = $clog2(WAITERS);

  logic [efg_pkg::MASK_W-1:0] flags;
  logic [efg_pkg::MASK_W-1:0] flags_next;
  logic [CW-1:0]              count;
  logic [CW-1:0]              count_next;
  logic [CW-1:0]              idx;
  logic [CW-1:0]              idx_next;
  logic [CW-1:0]              keep;
  logic [CW-1:0]              keep_next;
  logic                       rsp_valid_next;
  efg_pkg::rsp_t              rsp_next;
  logic                       load;

  efg_pkg::slot_t             rd_slot;
  efg_pkg::slot_t             wr_slot;
  logic                       we;
  logic [IW-1:0]              waddr;
  logic [IW-1:0]              raddr;

  logic [CW-1:0]              idx_inc;
  logic [efg_pkg::MASK_W-1:0] slot_match;
  logic                       hit;
  logic [efg_pkg::MASK_W-1:0] req_match;
  logic                       met;
  logic                       full;

  efg_ram #(
    .WIDTH (efg_pkg::SLOT_W),
    .DEPTH (WAITERS)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wr_slot),
    .raddr (raddr),
    .rdata (rd_slot)
  );

  assign idx_inc    = idx + CW'(1);
  assign slot_match = rd_slot.mask & flags;
  assign hit        = rd_slot.all ? (slot_match == rd_slot.mask) : (slot_match != '0);
  assign req_match  = req.bits & flags;
  assign met        = req.match_all ? (req_match == req.bits) : (req_match != '0);
  assign full       = (count == CW'(WAITERS));

  always_comb begin
    stat.is_send    = (req.operation == efg_pkg::OP_SEND);
    stat.empty      = (req.bits == '0);
    stat.count_zero = (count == '0);
    stat.slot_hit   = hit;
    stat.slot_last  = (idx_inc == count);
    stat.out_free   = !rsp_valid || !rsp_stall;
  end

  always_comb begin
    flags_next = flags;
    count_next = count;
    idx_next   = idx;
    keep_next  = keep;
    load       = 1'b0;
    rsp_next   = rsp;
    we         = 1'b0;
    waddr      = keep[IW-1:0];
    wr_slot    = rd_slot;
    raddr      = cmd.step ? idx_inc[IW-1:0] : idx[IW-1:0];

    if (cmd.take_in) begin
      raddr = '0;
      load  = 1'b1;
      rsp_next.woken_id   = req.waiter_id;
      rsp_next.taken_bits = '0;
      rsp_next.last       = 1'b1;
      if (req.operation == efg_pkg::OP_SEND) begin
        rsp_next.kind     = efg_pkg::KIND_DONE;
        rsp_next.status   = efg_pkg::ST_EMPTY;
        rsp_next.woken_id = '0;
        if (req.bits != '0) begin
          load       = 1'b0;
          flags_next = flags | req.bits;
          idx_next   = '0;
          keep_next  = '0;
        end
      end else begin
        rsp_next.kind = efg_pkg::KIND_RECV;
        if (req.bits == '0) begin
          rsp_next.status = efg_pkg::ST_EMPTY;
        end else if (met) begin
          rsp_next.status     = efg_pkg::ST_OK;
          rsp_next.taken_bits = req_match;
          if (req.clear_on_take) begin
            flags_next = flags & ~req.bits;
          end
        end else if (!req.may_wait) begin
          rsp_next.status = efg_pkg::ST_UNMET;
        end else if (full) begin
          rsp_next.status = efg_pkg::ST_FULL;
        end else begin
          rsp_next.status = efg_pkg::ST_QUEUED;
          we              = 1'b1;
          waddr           = count[IW-1:0];
          wr_slot.mask    = req.bits;
          wr_slot.id      = req.waiter_id;
          wr_slot.all     = req.match_all;
          wr_slot.clr     = req.clear_on_take;
          count_next      = count + CW'(1);
        end
      end
    end

    if (cmd.step) begin
      idx_next = idx_inc;
      if (hit) begin
        load                = 1'b1;
        rsp_next.kind       = efg_pkg::KIND_WAKE;
        rsp_next.status     = efg_pkg::ST_OK;
        rsp_next.woken_id   = rd_slot.id;
        rsp_next.taken_bits = slot_match;
        rsp_next.last       = 1'b0;
        if (rd_slot.clr) begin
          flags_next = flags & ~slot_match;
        end
      end else begin
        we        = 1'b1;
        keep_next = keep + CW'(1);
      end
    end

    if (cmd.emit_done) begin
      load                = 1'b1;
      rsp_next.kind       = efg_pkg::KIND_DONE;
      rsp_next.status     = efg_pkg::ST_OK;
      rsp_next.woken_id   = '0;
      rsp_next.taken_bits = '0;
      rsp_next.last       = 1'b1;
      count_next          = keep;
    end

    rsp_valid_next = load ? 1'b1 : (rsp_valid && rsp_stall);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      flags     <= flags_next;
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    idx  <= idx_next;
    keep <= keep_next;
    if (load) begin
      rsp <= rsp_next;
    end
  end

endmodule

`default_nettype wire
